>>> design/acdm_pkg.sv
package acdm_pkg;

  localparam int StoreDepth = 131072;
  localparam int AddrBits   = 17;
  localparam int CountBits  = 18;
  localparam int SampleBits = 16;
  localparam int FadeBits   = 17;

  localparam logic [FadeBits-1:0] FadeReset = FadeBits'(96000);

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [AddrBits-1:0]          addr_t;
  typedef logic [CountBits-1:0]         count_t;
  typedef logic [FadeBits-1:0]          fade_t;

  typedef enum logic [2:0] {
    MODE_SAMPLE = 3'd0,
    MODE_START  = 3'd1,
    MODE_FINISH = 3'd2,
    MODE_FLUSH  = 3'd3,
    MODE_DRAIN  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    PH_OFF     = 2'd0,
    PH_PRE     = 2'd1,
    PH_RUN     = 2'd2,
    PH_BETWEEN = 2'd3
  } phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,        // memory read issued
    ST_MUL,       // product registered
    ST_DIV,       // divider running
    ST_WR,        // write back / emit
    ST_WALK_RD,
    ST_WALK_MUL,
    ST_WALK_DIV,
    ST_WALK_WR
  } state_t;

  // divider request/response
  typedef struct packed {
    logic                   start;
    logic signed [40:0]     num;
    logic [CountBits-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [40:0]     quo;
  } div_rsp_t;

  function automatic sample_t sat_sample(input logic signed [41:0] v);
    if (v > 42'sd32767) return sample_t'(16'sd32767);
    if (v < -42'sd32768) return sample_t'(-16'sd32768);
    return v[SampleBits-1:0];
  endfunction

endpackage

>>> design/acdm_if.sv
interface acdm_in_if;
  import acdm_pkg::*;
  logic         valid;
  logic         ready;
  logic [2:0]   mode;
  sample_t      sample;
  modport source (output valid, mode, sample, input ready);
  modport sink (input valid, mode, sample, output ready);
endinterface

interface acdm_out_if;
  import acdm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_sample;
  logic    last;
  modport source (output valid, out_sample, last, input ready);
  modport sink (input valid, out_sample, last, output ready);
endinterface

>>> design/acdm_div.sv
module acdm_div
  import acdm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NumBits = 41;

  logic [NumBits-1:0]   rem_mag;
  logic [NumBits-1:0]   quo_mag;
  logic [CountBits:0]   part;
  logic [CountBits-1:0] den;
  logic                 neg;
  logic [5:0]           cnt;
  logic                 busy;
  logic                 done;
  logic [CountBits:0]   shifted;
  logic [CountBits:0]   diff;

  // one quotient bit per cycle, restoring, on magnitudes
  always_comb begin
    shifted = {part[CountBits-1:0], rem_mag[NumBits-1]};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 6'd1);
      if (req.start) begin
        busy    <= 1'b1;
        neg     <= req.num[NumBits-1];
        rem_mag <= req.num[NumBits-1] ? NumBits'(-req.num) : req.num;
        part    <= '0;
        den     <= req.den;
        cnt     <= 6'(NumBits);
      end else if (busy) begin
        rem_mag <= {rem_mag[NumBits-2:0], 1'b0};
        if (!diff[CountBits]) begin
          part    <= diff;
          quo_mag <= {quo_mag[NumBits-2:0], 1'b1};
        end else begin
          part    <= shifted;
          quo_mag <= {quo_mag[NumBits-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) busy <= 1'b0;
      end
    end
  end

  assign rsp = {done, neg ? -$signed(quo_mag) : $signed(quo_mag)};

endmodule

>>> design/acdm_ctrl.sv
module acdm_ctrl
  import acdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  fade_t      fade,
  acdm_in_if.sink    in_ch,
  acdm_out_if.source out_ch
);

  // delay store, read data registered
  sample_t store [StoreDepth];
  sample_t rd_data;
  addr_t   rd_addr;
  logic    wr_en;
  addr_t   wr_addr;
  sample_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
    rd_data <= store[rd_addr];
  end

  state_t state, state_next;
  phase_t phase;
  addr_t  head;
  count_t fill, pos, walk;
  sample_t smp;
  logic   [1:0] op;      // 0 mix into entry, 1 append, 2 pop/emit
  count_t mpos;
  logic   scaled;
  div_req_t dreq;
  div_rsp_t drsp;
  logic   ov_valid;
  sample_t ov_sample;
  logic   ov_last;
  count_t fade_len;
  logic   pre_mix;
  count_t nf;
  logic   to_run;
  logic   emit;
  logic   acc;
  addr_t  mslot;
  logic signed [40:0] addend;

  localparam logic [1:0] OpMix = 2'd0, OpApp = 2'd1, OpPop = 2'd2;

  acdm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (state == ST_IDLE) && !ov_valid;
  assign out_ch.valid = ov_valid;
  assign out_ch.out_sample = ov_sample;
  assign out_ch.last = ov_last;

  assign acc = in_ch.valid && in_ch.ready;
  assign fade_len = count_t'(fade);
  assign pre_mix = (phase == PH_PRE) && (pos < fade_len || pos < fill);

  assign mslot = head + mpos[AddrBits-1:0];

  // store port addressing
  assign rd_addr = (state == ST_WALK_RD) ? head + walk[AddrBits-1:0] : mslot;

  // fill and phase after a mix or append
  always_comb begin
    nf = (op == OpApp) ? fill + 1'b1 : fill;
    to_run = (phase == PH_PRE) && (pos >= fade_len) && (pos >= nf);
    emit = (phase == PH_RUN || to_run) && (nf > fade_len);
  end

  // value to be mixed or written
  always_comb begin
    addend = scaled ? drsp.quo : 41'(smp);
    wr_en = 1'b0;
    wr_addr = mslot;
    wr_data = smp;
    if (state == ST_WR && op == OpMix) begin
      wr_en = 1'b1;
      wr_data = sat_sample(42'(rd_data) + 42'(addend));
    end else if (state == ST_WR && op == OpApp) begin
      wr_en = 1'b1;
      wr_data = sat_sample(42'(addend));
    end else if (state == ST_WALK_WR) begin
      wr_en = 1'b1;
      wr_addr = head + walk[AddrBits-1:0];
      wr_data = drsp.quo[SampleBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_ch.mode)
            MODE_SAMPLE: begin
              if (phase == PH_PRE || phase == PH_RUN) state_next = ST_RD;
            end
            MODE_FINISH: begin
              if ((phase == PH_PRE || phase == PH_RUN) && fill != '0) state_next = ST_WALK_RD;
            end
            MODE_DRAIN: begin
              if (phase == PH_BETWEEN && fill != '0) state_next = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_next = (op == OpPop) ? ST_WR : (scaled ? ST_MUL : ST_WR);
      ST_MUL: state_next = ST_DIV;
      ST_DIV: if (drsp.done) state_next = ST_WR;
      ST_WR: state_next = (op != OpPop && emit) ? ST_RD : ST_IDLE;
      ST_WALK_RD: state_next = ST_WALK_MUL;
      ST_WALK_MUL: state_next = ST_WALK_DIV;
      ST_WALK_DIV: if (drsp.done) state_next = ST_WALK_WR;
      ST_WALK_WR: state_next = (walk + 1'b1 < fill) ? ST_WALK_RD : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OFF;
      head <= '0;
      fill <= '0;
      pos <= '0;
      walk <= '0;
      ov_valid <= 1'b0;
      op <= OpMix;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= (state == ST_MUL) || (state == ST_WALK_MUL);
      if (state == ST_WR && op == OpPop) ov_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            smp <= in_ch.sample;
            unique case (in_ch.mode)
              MODE_SAMPLE: begin
                if (pre_mix) begin
                  scaled <= pos < fade_len;
                  mpos <= pos;
                  op <= (pos < fill) ? OpMix : OpApp;
                  pos <= pos + 1'b1;
                end else if (phase == PH_PRE || phase == PH_RUN) begin
                  // plain delay: append while the store has room, pop directly once it is full
                  phase <= PH_RUN;
                  scaled <= 1'b0;
                  if (fill < count_t'(StoreDepth)) begin
                    mpos <= fill;
                    op <= OpApp;
                  end else begin
                    mpos <= '0;
                    op <= OpPop;
                  end
                end
              end
              MODE_START: begin
                if (phase != PH_BETWEEN) begin
                  head <= '0;
                  fill <= '0;
                end
                phase <= PH_PRE;
                pos <= '0;
              end
              MODE_FINISH: begin
                if (phase == PH_PRE || phase == PH_RUN) begin
                  phase <= PH_BETWEEN;
                  walk <= '0;
                end
              end
              MODE_FLUSH: begin
                if (phase == PH_PRE || phase == PH_RUN) begin
                  phase <= PH_RUN;
                  head <= '0;
                  fill <= '0;
                end
              end
              MODE_DRAIN: begin
                if (phase == PH_BETWEEN) begin
                  if (fill == '0) phase <= PH_OFF;
                  else begin
                    op <= OpPop;
                    mpos <= '0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          dreq.num <= 41'(smp) * $signed({1'b0, mpos});
          dreq.den <= fade_len;
        end
        ST_WR: begin
          if (op == OpPop) begin
            ov_sample <= rd_data;
            ov_last <= (phase == PH_BETWEEN) && (fill == count_t'(1));
            head <= head + 1'b1;
            fill <= fill - 1'b1;
            if (phase == PH_BETWEEN && fill == count_t'(1)) phase <= PH_OFF;
          end else begin
            fill <= nf;
            if (to_run) phase <= PH_RUN;
            // running: emit oldest if over length
            if (emit) begin
              op <= OpPop;
              mpos <= '0;
            end
          end
        end
        ST_WALK_MUL: begin
          dreq.num <= 41'(rd_data) * $signed({1'b0, fill - walk});
          dreq.den <= fill;
        end
        ST_WALK_WR: walk <= walk + 1'b1;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= count_t'(StoreDepth))
    else $error("fill beyond depth");
  a_nopop_off: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_RD) |-> phase == PH_BETWEEN) else $error("walk outside between");
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last) |-> phase == PH_OFF) else $error("last but not off");
`endif

endmodule

>>> design/audio_crossfade_delay_mixer.sv
// channel  dir  payload
// cfg      in   cfg_we, cfg_data (fade_samples, 17 b)
// in_ch    in   mode (3 b), sample (16 b signed)
// out_ch   out  out_sample (16 b signed), last
// a control item is handled in the idle state; a sample passes a read state (registered
// store read), then multiply and divide states on a scaled fade-in, then a write state
// a pop adds another read and write state, then input waits until the result beat leaves
// a finish walk reads, multiplies, divides and writes back each stored sample, input held off meanwhile
// synchronous active-high reset; store contents undefined after reset
module audio_crossfade_delay_mixer
  import acdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  fade_t      cfg_data,
  acdm_in_if.sink    in_ch,
  acdm_out_if.source out_ch
);

  fade_t fade;

  // fade length register
  always_ff @(posedge clk) begin
    if (rst) fade <= FadeReset;
    else if (cfg_we) fade <= cfg_data;
  end

  acdm_ctrl u_ctrl (.clk(clk), .rst(rst), .fade(fade), .in_ch(in_ch), .out_ch(out_ch));

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import acdm_pkg::*;

  localparam int WatchdogLimit = 60000;
  localparam int SettleCycles  = 6000;
  localparam int EndCycles     = 2000;

  typedef struct {
    sample_t    smp;
    logic       last;
  } beat_t;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  fade_t cfg_data;

  acdm_in_if  in_ch ();
  acdm_out_if out_ch ();

  audio_crossfade_delay_mixer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // mirror of the mixer state
  sample_t     mirror_mem [StoreDepth];
  phase_t      mirror_phase;
  int unsigned mirror_head;
  int unsigned mirror_fill;
  int unsigned mirror_pre_pos;
  int unsigned mirror_fade;

  beat_t       pending_beats [$];
  int          error_count;
  int          send_gap_pct;
  int          recv_gap_pct;
  int          recv_hold_cycles;
  int          quiet_cycles;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned store_slot(int unsigned off);
    return (mirror_head + off) % StoreDepth;
  endfunction

  function automatic sample_t clamp_q15(longint v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  function automatic void mix_into(int unsigned pos, longint v);
    int unsigned k;
    k = store_slot(pos);
    if (pos < mirror_fill) begin
      mirror_mem[k] = clamp_q15(longint'(mirror_mem[k]) + v);
    end else if (pos == mirror_fill && mirror_fill < StoreDepth) begin
      mirror_mem[k] = clamp_q15(v);
      mirror_fill++;
    end
  endfunction

  function automatic sample_t pop_oldest_sample();
    sample_t v;
    v = mirror_mem[mirror_head];
    mirror_head = (mirror_head + 1) % StoreDepth;
    mirror_fill--;
    return v;
  endfunction

  // expected result of one accepted beat; returns 1 when a beat comes out
  function automatic bit predict_mix(input logic [2:0] m, input sample_t s, output beat_t b);
    bit          used;
    longint      sv;
    int unsigned i;
    int unsigned k;
    int unsigned full;
    used = 1'b0;
    sv   = longint'(s);
    full = mirror_fade;
    b.smp  = '0;
    b.last = 1'b0;
    if (m == MODE_SAMPLE) begin
      if (mirror_phase == PH_PRE) begin
        if (mirror_pre_pos < full) begin
          mix_into(mirror_pre_pos, (sv * longint'(mirror_pre_pos)) / longint'(full));
          mirror_pre_pos++;
          used = 1'b1;
        end
        if (!used && mirror_pre_pos < mirror_fill) begin
          mix_into(mirror_pre_pos, sv);
          mirror_pre_pos++;
          used = 1'b1;
        end
        if (mirror_pre_pos >= full && mirror_pre_pos >= mirror_fill) mirror_phase = PH_RUN;
      end
      if (mirror_phase == PH_RUN) begin
        if (!used && mirror_fill < StoreDepth) begin
          mirror_mem[store_slot(mirror_fill)] = s;
          mirror_fill++;
        end
        if (mirror_fill > full) begin
          b.smp = pop_oldest_sample();
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (m == MODE_START) begin
      if (mirror_phase != PH_BETWEEN) begin
        mirror_head = 0;
        mirror_fill = 0;
      end
      mirror_phase   = PH_PRE;
      mirror_pre_pos = 0;
      return 1'b0;
    end
    if (m == MODE_FINISH) begin
      if (mirror_phase == PH_PRE || mirror_phase == PH_RUN) begin
        // linear fade-out of the held tail
        for (i = 0; i < mirror_fill; i++) begin
          k = store_slot(i);
          mirror_mem[k] = sample_t'((longint'(mirror_mem[k]) * longint'(mirror_fill - i))
                                    / longint'(mirror_fill));
        end
        mirror_phase = PH_BETWEEN;
      end
      return 1'b0;
    end
    if (m == MODE_FLUSH) begin
      if (mirror_phase == PH_PRE || mirror_phase == PH_RUN) begin
        mirror_phase = PH_RUN;
        mirror_head  = 0;
        mirror_fill  = 0;
      end
      return 1'b0;
    end
    if (m == MODE_DRAIN && mirror_phase == PH_BETWEEN) begin
      if (mirror_fill == 0) begin
        mirror_phase = PH_OFF;
        return 1'b0;
      end
      b.smp  = pop_oldest_sample();
      b.last = (mirror_fill == 0);
      if (mirror_fill == 0) mirror_phase = PH_OFF;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one input beat, with random gaps in front of it
  task automatic send_beat(input logic [2:0] m, input sample_t s);
    beat_t b;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= m;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_mix(m, s, b)) pending_beats.push_back(b);
  endtask

  task automatic send_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_fade(input int unsigned v);
    cfg_we   <= 1'b1;
    cfg_data <= fade_t'(v);
    @(posedge clk);
    cfg_we   <= 1'b0;
    mirror_fade = v;
  endtask

  // wait for all results, then let a finish walk run out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_samples(input int n);
    int i;
    for (i = 0; i < n; i++) send_beat(MODE_SAMPLE, sample_t'($urandom));
  endtask

  task automatic drain_all();
    while (mirror_phase == PH_BETWEEN) send_beat(MODE_DRAIN, '0);
  endtask

  // ignored items, extremes, flush, crossfade with a kept tail
  task automatic test_directed();
    send_beat(MODE_SAMPLE, sample_t'(1234));
    send_beat(MODE_DRAIN, '0);
    send_beat(MODE_FINISH, '0);
    send_beat(MODE_FLUSH, '0);
    send_beat(3'd5, '0);
    send_beat(3'd6, '0);
    send_beat(3'd7, '0);
    send_idle();
    settle();
    write_fade(4);
    send_beat(MODE_START, '0);
    send_beat(MODE_SAMPLE, sample_t'(32767));
    send_beat(MODE_SAMPLE, sample_t'(-32768));
    send_beat(MODE_SAMPLE, sample_t'(-1));
    send_beat(MODE_SAMPLE, sample_t'(32767));
    send_beat(MODE_SAMPLE, sample_t'(-32768));
    send_beat(MODE_SAMPLE, sample_t'(0));
    send_beat(MODE_FLUSH, '0);
    send_samples(6);
    send_beat(MODE_FINISH, '0);
    // new song on top of the faded tail, saturating sums
    send_beat(MODE_START, '0);
    send_beat(MODE_SAMPLE, sample_t'(32767));
    send_beat(MODE_SAMPLE, sample_t'(32767));
    send_beat(MODE_SAMPLE, sample_t'(-32768));
    send_beat(MODE_SAMPLE, sample_t'(-32768));
    send_beat(MODE_FINISH, '0);
    drain_all();
    send_beat(MODE_DRAIN, '0);
    send_idle();
  endtask

  // zero and largest fade lengths
  task automatic test_fade_extremes();
    settle();
    write_fade(0);
    send_beat(MODE_START, '0);
    send_samples(5);
    send_beat(MODE_FINISH, '0);
    send_beat(MODE_SAMPLE, sample_t'(77));
    send_beat(MODE_FINISH, '0);
    drain_all();
    send_idle();
    settle();
    write_fade(131071);
    send_beat(MODE_START, '0);
    send_samples(8);
    send_beat(MODE_FINISH, '0);
    drain_all();
    send_idle();
  endtask

  // well-formed songs with random content, some noise and broken sequences
  task automatic test_random_songs(input int n_items);
    int sent;
    int len;
    int i;
    int pick;
    sent = 0;
    settle();
    write_fade($urandom_range(48, 1));
    while (sent < n_items) begin
      send_beat(MODE_START, '0);
      len = $urandom_range(60, 1);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(99);
        if (pick < 2) send_beat(MODE_FLUSH, '0);
        else if (pick < 4) begin
          send_beat(3'($urandom_range(7, int'(MODE_DRAIN) + 1)), sample_t'($urandom));
        end
        else if (pick < 6) send_beat(MODE_DRAIN, '0);
        else if (pick < 10) begin
          send_beat(MODE_SAMPLE, $urandom_range(1) ? sample_t'(32767) : sample_t'(-32768));
        end
        else send_beat(MODE_SAMPLE, sample_t'($urandom));
      end
      sent += len + 1;
      if ($urandom_range(9) != 0) begin
        send_beat(MODE_FINISH, '0);
        sent++;
        // partial drain keeps a tail for the next crossfade
        if ($urandom_range(2) == 0) begin
          len = $urandom_range(mirror_fill);
          for (i = 0; i < len; i++) send_beat(MODE_DRAIN, '0);
          sent += len;
        end else begin
          while (mirror_phase == PH_BETWEEN) begin
            send_beat(MODE_DRAIN, '0);
            sent++;
          end
        end
      end
    end
    send_idle();
  endtask

  // receiver holds off while samples keep coming, then the sender waits out the results
  task automatic test_backpressure();
    settle();
    write_fade(3);
    send_beat(MODE_START, '0);
    send_samples(10);
    recv_hold_cycles = 400;
    send_samples(40);
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    send_samples(10);
    send_beat(MODE_FINISH, '0);
    drain_all();
    send_idle();
  endtask

  // receiver ready, random stalls and long hold-off
  always @(posedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    beat_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat out_sample %0d last %0d", out_ch.out_sample, out_ch.last);
        error_count++;
      end else begin
        e = pending_beats.pop_front();
        if (out_ch.out_sample !== e.smp) begin
          $error("out_sample expected %0d actual %0d", e.smp, out_ch.out_sample);
          error_count++;
        end
        if (out_ch.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_SAMPLE;
    in_ch.sample     = '0;
    out_ch.ready     = 1'b0;
    error_count      = 0;
    quiet_cycles     = 0;
    recv_hold_cycles = 0;
    send_gap_pct     = 8;
    recv_gap_pct     = 72;
    mirror_phase     = PH_OFF;
    mirror_head      = 0;
    mirror_fill      = 0;
    mirror_pre_pos   = 0;
    mirror_fade      = 96000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fade_extremes();
    test_random_songs(100);
    send_gap_pct = 72;
    recv_gap_pct = 8;
    test_random_songs(100);
    test_backpressure();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_songs(100);

    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (EndCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/acdm_pkg.sv
design/acdm_if.sv
design/acdm_div.sv
design/acdm_ctrl.sv
design/audio_crossfade_delay_mixer.sv
tb/testbench.sv
